[rtl/spbp_pkg.sv]
// Shared constants for the size-prefixed bit packer.
// No dependencies; imported by every module of the block.
package spbp_pkg;

  localparam int VALUE_BITS           = 32;
  localparam int WORD_BITS            = 32;
  localparam int SIZE_FIELD_BITS_DEF  = 6;
  localparam int QUEUE_DEPTH          = 2;

endpackage

[rtl/size_prefixed_bit_packer_unit.sv]
// Size-prefixed bit packer: each signed sample is written as a SIZE_FIELD_BITS count n followed
// by its low n bits, MSB first, into 32-bit words; end_of_stream flushes a zero-padded word.
// Words, a flush word included, leave through the word output register at one word per cycle
// while out_stall is low.
// An input beat passes through the front-end register, a queue entry and the bit window before
// the word output register; the front end and the back end are joined by a two-entry queue so
// either side may stall alone.
module size_prefixed_bit_packer_unit import spbp_pkg::*; #(
  parameter int SIZE_FIELD_BITS = SIZE_FIELD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] sample_value,
  input  logic                  end_of_stream,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [WORD_BITS-1:0]  packed_word,
  output logic                  last_word
);

  localparam int CHUNK_W = SIZE_FIELD_BITS + VALUE_BITS;
  localparam int LEN_W   = $clog2(CHUNK_W + 1);
  localparam int DATA_W  = 1 + LEN_W + CHUNK_W;

  logic               f_valid;
  logic               f_stall;
  logic [CHUNK_W-1:0] f_chunk;
  logic [LEN_W-1:0]   f_len;
  logic               f_eos;
  logic               q_valid;
  logic               q_stall;
  logic [DATA_W-1:0]  q_data;
  logic [CHUNK_W-1:0] q_chunk;
  logic [LEN_W-1:0]   q_len;
  logic               q_eos;

  assign q_chunk = q_data[CHUNK_W-1:0];
  assign q_len   = q_data[CHUNK_W +: LEN_W];
  assign q_eos   = q_data[DATA_W-1];

  spbp_front #(
    .SIZE_FIELD_BITS (SIZE_FIELD_BITS),
    .CHUNK_W         (CHUNK_W),
    .LEN_W           (LEN_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sample_value  (sample_value),
    .end_of_stream (end_of_stream),
    .f_valid       (f_valid),
    .f_stall       (f_stall),
    .f_chunk       (f_chunk),
    .f_len         (f_len),
    .f_eos         (f_eos)
  );

  spbp_queue #(
    .DATA_W (DATA_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_stall (f_stall),
    .wr_data  ({f_eos, f_len, f_chunk}),
    .rd_valid (q_valid),
    .rd_stall (q_stall),
    .rd_data  (q_data)
  );

  spbp_back #(
    .CHUNK_W (CHUNK_W),
    .LEN_W   (LEN_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_stall     (q_stall),
    .q_chunk     (q_chunk),
    .q_len       (q_len),
    .q_eos       (q_eos),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .packed_word (packed_word),
    .last_word   (last_word)
  );

endmodule

[rtl/spbp_front.sv]
// Front end: accepts samples, finds the bit count and builds the size-prefixed chunk.
// Depends on spbp_pkg; feeds spbp_queue.
module spbp_front import spbp_pkg::*; #(
  parameter int SIZE_FIELD_BITS = SIZE_FIELD_BITS_DEF,
  parameter int CHUNK_W         = SIZE_FIELD_BITS + VALUE_BITS,
  parameter int LEN_W           = $clog2(CHUNK_W + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] sample_value,
  input  logic                  end_of_stream,
  output logic                  f_valid,
  input  logic                  f_stall,
  output logic [CHUNK_W-1:0]    f_chunk,
  output logic [LEN_W-1:0]      f_len,
  output logic                  f_eos
);

  localparam int NB_W = $clog2(VALUE_BITS + 2);

  logic [VALUE_BITS-1:0]   mag;
  logic [NB_W-1:0]         mag_len;
  logic [NB_W-1:0]         n_raw;
  logic [NB_W-1:0]         n;
  logic [VALUE_BITS:0]     low_mask;
  logic [CHUNK_W-1:0]      chunk_next;
  logic [LEN_W-1:0]        len_next;
  logic                    accept;

  always_comb begin
    mag = sample_value[VALUE_BITS-1] ? (~sample_value + VALUE_BITS'(1)) : sample_value;
    mag_len = '0;
    for (int i = 0; i < VALUE_BITS; i++) begin
      if (mag[i]) begin
        mag_len = NB_W'(i + 1);
      end
    end
    n_raw = mag_len + NB_W'(1);
    n = (n_raw > NB_W'(VALUE_BITS)) ? NB_W'(VALUE_BITS) : n_raw;
    low_mask = ~({(VALUE_BITS + 1){1'b1}} << n);
    chunk_next = (CHUNK_W'(SIZE_FIELD_BITS'(n)) << n)
               | CHUNK_W'(sample_value & low_mask[VALUE_BITS-1:0]);
    len_next = LEN_W'(SIZE_FIELD_BITS) + LEN_W'(n);
  end

  assign in_stall = f_valid && f_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (!f_stall) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_chunk <= chunk_next;
      f_len   <= len_next;
      f_eos   <= end_of_stream;
    end
  end

endmodule

[rtl/spbp_queue.sv]
// Short register queue between front and back ends.
// Depends on spbp_pkg for its default depth.
module spbp_queue import spbp_pkg::*; #(
  parameter int DATA_W = 48,
  parameter int DEPTH  = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_stall,
  input  logic [DATA_W-1:0] wr_data,
  output logic              rd_valid,
  input  logic              rd_stall,
  output logic [DATA_W-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  assign wr_stall = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && !rd_stall;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

[rtl/spbp_back.sv]
// Back end: merges chunks into the bit window and emits 32-bit words, flushing at end of stream.
// Depends on spbp_pkg; reads from spbp_queue.
module spbp_back import spbp_pkg::*; #(
  parameter int CHUNK_W = SIZE_FIELD_BITS_DEF + VALUE_BITS,
  parameter int LEN_W   = $clog2(CHUNK_W + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_stall,
  input  logic [CHUNK_W-1:0]   q_chunk,
  input  logic [LEN_W-1:0]     q_len,
  input  logic                 q_eos,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_BITS-1:0] packed_word,
  output logic                 last_word
);

  localparam int COMB_W = WORD_BITS + CHUNK_W;
  localparam int CNT_W  = $clog2(COMB_W);
  localparam int WSH_W  = $clog2(WORD_BITS);

  logic [COMB_W-1:0]    comb;
  logic [CNT_W-1:0]     cnt;
  logic                 eos_pend;

  logic                 emit_full;
  logic                 emit_need;
  logic [CNT_W-1:0]     cnt_sub;
  logic [CNT_W-1:0]     cnt1;
  logic                 eos1;
  logic                 out_free;
  logic                 adv;
  logic                 can_load;
  logic                 pop;
  logic [WORD_BITS-1:0] word_next;
  logic                 last_next;
  logic [WSH_W-1:0]     flush_sh;
  logic [CNT_W-1:0]     flush_diff;

  always_comb begin
    emit_full  = (cnt >= CNT_W'(WORD_BITS));
    cnt_sub    = cnt - CNT_W'(WORD_BITS);
    flush_diff = CNT_W'(WORD_BITS) - cnt;
    flush_sh   = flush_diff[WSH_W-1:0];
    emit_need  = emit_full || (eos_pend && (cnt != '0));
    out_free   = !out_valid || !out_stall;
    adv        = !emit_need || out_free;
    priority if (emit_full) begin
      cnt1      = cnt_sub;
      word_next = WORD_BITS'(comb >> cnt_sub);
      last_next = eos_pend && (cnt_sub == '0);
    end else if (eos_pend && (cnt != '0)) begin
      cnt1      = '0;
      word_next = comb[WORD_BITS-1:0] << flush_sh;
      last_next = 1'b1;
    end else begin
      cnt1      = cnt;
      word_next = '0;
      last_next = 1'b0;
    end
    eos1     = eos_pend && (cnt1 != '0);
    can_load = (cnt1 < CNT_W'(WORD_BITS)) && !eos1;
    pop      = q_valid && adv && can_load;
    q_stall  = !(adv && can_load);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      eos_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv && emit_need) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (adv) begin
        cnt      <= pop ? (cnt1 + CNT_W'(q_len)) : cnt1;
        eos_pend <= pop ? q_eos : eos1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit_need) begin
      packed_word <= word_next;
      last_word   <= last_next;
    end
    if (pop) begin
      comb <= (comb << q_len) | COMB_W'(q_chunk);
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt < CNT_W'(COMB_W))
    else $error("bit window count out of range");

  a_eos_has_bits: assert property (@(posedge clk) disable iff (rst) eos_pend |-> (cnt != '0))
    else $error("end of stream pending with empty window");

  a_pop_no_block: assert property (@(posedge clk) disable iff (rst)
      pop |-> !(emit_need && !out_free))
    else $error("chunk taken while word output blocked");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
      (adv && emit_need && last_next && !pop) |=> (cnt == '0 && !eos_pend))
    else $error("window not empty after last word");

endmodule
